[rtl/assert_macros.svh]
// Assertion macros shared by the ADPCM decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// Condition that must never hold, checked out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`endif

[rtl/mad_pkg.sv]
// Shared types and constants of the ADPCM decoder.
package mad_pkg;

    // Step size limits and sample saturation bounds
    localparam logic [14:0]        STEP_MIN = 15'd127;
    localparam logic [14:0]        STEP_MAX = 15'd24576;
    localparam logic signed [15:0] SIG_MAX  = 16'sh7fff;
    localparam logic signed [15:0] SIG_MIN  = -16'sh8000;

    // Step adaptation factors, indexed by code magnitude (Q8)
    localparam logic [9:0] SCALE [8] = '{
        10'h0e6, 10'h0e6, 10'h0e6, 10'h0e6, 10'h133, 10'h199, 10'h200, 10'h266
    };

    // Input command codes
    localparam logic CMD_DECODE = 1'b0;
    localparam logic CMD_KEY_ON = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_HI,
        S_LO,
        S_KEY
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // latch the incoming word
        logic nib_en;   // decode one nibble, update channel state, load output
        logic nib_lo;   // low nibble selected, marks the last sample
        logic key_on;   // reset the latched channel
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic ch_ok;    // incoming channel is within range
        logic out_free; // output register can take a sample this cycle
    } t_dp_sts;

endpackage

[rtl/mad_ctrl.sv]
// Sequencing state machine of the ADPCM decoder.
`include "assert_macros.svh"
module mad_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_command,
    output logic             o_stall,
    input  mad_pkg::t_dp_sts i_sts,
    output mad_pkg::t_dp_cmd o_cmd
);
    import mad_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_ready;
    logic   accept;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        in_ready = 1'b0;
        accept   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
            end
            S_HI: begin
                if (i_sts.out_free) begin
                    o_cmd.nib_en = 1'b1;
                    n_state      = S_LO;
                end
            end
            S_LO: begin
                if (i_sts.out_free) begin
                    o_cmd.nib_en = 1'b1;
                    o_cmd.nib_lo = 1'b1;
                    in_ready     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_KEY: begin
                o_cmd.key_on = 1'b1;
                in_ready     = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Take the next word and dispatch it
        accept = in_ready && i_valid;
        if (accept) begin
            o_cmd.load = 1'b1;
            if (!i_sts.ch_ok) begin
                n_state = S_IDLE;
            end else if (i_command == CMD_KEY_ON) begin
                n_state = S_KEY;
            end else begin
                n_state = S_HI;
            end
        end
    end

    assign o_stall = !in_ready;

    `ASSERT_NEVER(a_key_and_nib, i_clk, i_rst_n, o_cmd.key_on && o_cmd.nib_en)
    `ASSERT_NEXT(a_hi_to_lo, i_clk, i_rst_n, (r_state == S_HI) && i_sts.out_free,
        r_state == S_LO)

endmodule

[rtl/mad_dp.sv]
// Per-channel state, nibble decode arithmetic and output register.
`include "assert_macros.svh"
module mad_dp #(
    parameter int VOICES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mad_pkg::t_dp_cmd   i_cmd,
    output mad_pkg::t_dp_sts   o_sts,
    input  logic [2:0]         i_channel,
    input  logic [7:0]         i_data_byte,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [2:0]         o_voice,
    output logic signed [15:0] o_sample,
    output logic [14:0]        o_step_size,
    output logic               o_last
);
    import mad_pkg::*;

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    // Channel state
    logic signed [15:0] r_sig  [VOICES];
    logic [14:0]        r_step [VOICES];

    // Latched word
    logic [IDX_W-1:0]   r_idx;
    logic [2:0]         r_channel;
    logic [7:0]         r_byte;

    // Output register
    logic               r_out_valid;
    logic [2:0]         r_voice;
    logic signed [15:0] r_sample;
    logic [14:0]        r_step_out;
    logic               r_last;

    // Nibble arithmetic
    logic [3:0]         code;
    logic [2:0]         mag;
    logic [14:0]        cur_step;
    logic signed [15:0] cur_sig;
    logic [18:0]        diff_prod;
    logic signed [19:0] diff_signed;
    logic signed [19:0] delta;
    logic signed [20:0] sum;
    logic signed [15:0] n_sig;
    logic [24:0]        step_prod;
    logic [16:0]        step_raw;
    logic [14:0]        n_step;
    logic               out_taken;

    // Status to the controller
    assign o_sts.ch_ok    = (32'(i_channel) < VOICES);
    assign out_taken      = r_out_valid && !i_stall;
    assign o_sts.out_free = !r_out_valid || !i_stall;

    // Decode the selected nibble against the channel state
    always_comb begin
        code        = i_cmd.nib_lo ? r_byte[3:0] : r_byte[7:4];
        mag         = code[2:0];
        cur_step    = r_step[r_idx];
        cur_sig     = r_sig[r_idx];
        diff_prod   = 19'(cur_step) * 19'({mag, 1'b1});
        diff_signed = code[3] ? -$signed({1'b0, diff_prod}) : $signed({1'b0, diff_prod});
        delta       = diff_signed >>> 3;
        sum         = 21'(cur_sig) + 21'(delta);
        if (sum > 21'(SIG_MAX)) begin
            n_sig = SIG_MAX;
        end else if (sum < 21'(SIG_MIN)) begin
            n_sig = SIG_MIN;
        end else begin
            n_sig = sum[15:0];
        end
        step_prod = 25'(cur_step) * 25'(SCALE[mag]);
        step_raw  = step_prod[24:8];
        if (step_raw > 17'(STEP_MAX)) begin
            n_step = STEP_MAX;
        end else if (step_raw < 17'(STEP_MIN)) begin
            n_step = STEP_MIN;
        end else begin
            n_step = step_raw[14:0];
        end
    end

    // Latch the incoming word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx     <= IDX_W'(i_channel);
            r_channel <= i_channel;
            r_byte    <= i_data_byte;
        end
    end

    // Update channel state: key-on resets, a decoded nibble writes back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                r_sig[v]  <= '0;
                r_step[v] <= STEP_MIN;
            end
        end else if (i_cmd.key_on) begin
            r_sig[r_idx]  <= '0;
            r_step[r_idx] <= STEP_MIN;
        end else if (i_cmd.nib_en) begin
            r_sig[r_idx]  <= n_sig;
            r_step[r_idx] <= n_step;
        end
    end

    // Output valid: set on a new sample, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.nib_en) begin
            r_out_valid <= 1'b1;
        end else if (out_taken) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.nib_en) begin
            r_voice    <= r_channel;
            r_sample   <= n_sig;
            r_step_out <= n_step;
            r_last     <= i_cmd.nib_lo;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_voice     = r_voice;
    assign o_sample    = r_sample;
    assign o_step_size = r_step_out;
    assign o_last      = r_last;

    `ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, i_cmd.nib_en, !r_out_valid || !i_stall)

endmodule

[rtl/multichannel_adpcm_decoder.sv]
// Top level of the eight-channel 4-bit ADPCM decoder.
//
// Each input word names a channel and either keys it on (signal 0, step 127,
// no output) or carries a byte of two ADPCM codes, which gives two samples:
// high nibble first (o_last low), then low nibble (o_last high). One shared
// nibble unit reads the channel's signal and step, applies the difference and
// the step adaptation, and writes both back, so a data word is decoded over
// the states S_HI and S_LO, and the next data word is accepted in S_LO while
// the output is not stalled. A key-on word resets its channel in the cycle
// after its acceptance; a word naming a channel at or above VOICES is taken
// and dropped. A registered output stage lets the next word be accepted while
// the last sample of the previous one still waits to be taken.
module multichannel_adpcm_decoder #(
    parameter int VOICES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_command,
    input  logic [2:0]         i_channel,
    input  logic [7:0]         i_data_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_voice,
    output logic signed [15:0] o_sample,
    output logic [14:0]        o_step_size,
    output logic               o_last
);
    import mad_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequence each word
    mad_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_stall   (o_stall),
        .i_sts     (dp_sts),
        .o_cmd     (dp_cmd)
    );

    // Decode and hold channel state
    mad_dp #(
        .VOICES (VOICES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_channel   (i_channel),
        .i_data_byte (i_data_byte),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_voice     (o_voice),
        .o_sample    (o_sample),
        .o_step_size (o_step_size),
        .o_last      (o_last)
    );

endmodule
